[rtl/core/pvas_pkg.sv]
// Shared types, codes and address tables for the planar video memory block.
`timescale 1ns / 1ps

package pvas_pkg;

    // Width of a video memory byte index and of a plane byte offset.
    localparam int IDX_W = 17;
    localparam int OFF_W = 14;

    // Depth of the command queue between the front and back parts.
    localparam int Q_DEPTH = 2;

    // Number of plane bytes read by one display fetch in each mode.
    localparam int PLANES_640 = 3;
    localparam int PLANES_320 = 12;

    // Operation codes of an input beat.
    localparam logic [1:0] OP_READ          = 2'd0;
    localparam logic [1:0] OP_WRITE_GATED   = 2'd1;
    localparam logic [1:0] OP_WRITE_UNGATED = 2'd2;
    localparam logic [1:0] OP_FETCH         = 2'd3;

    // Configuration register indexes.
    localparam logic [2:0] REG_PLANE_MASK    = 3'd0;
    localparam logic [2:0] REG_SCROLL_OFFSET = 3'd1;
    localparam logic [2:0] REG_ACTIVE_PAGE   = 3'd2;
    localparam logic [2:0] REG_CPU_ENABLE    = 3'd3;
    localparam logic [2:0] REG_MODE_320      = 3'd4;
    localparam logic [2:0] REG_DISPLAY_EN    = 3'd5;

    // Result kinds.
    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_PIXEL = 1'b1;

    localparam logic [IDX_W-1:0] PAGE_OFFSET = 17'h0C000;
    localparam logic [7:0]       BYTE_MASKED = 8'hFF;
    localparam logic [12:0]      COLOR_BASE_320 = 13'd8;

    // Plane base addresses, in the order the bits of a pixel index are built.
    localparam logic [IDX_W-1:0] BASE_640 [PLANES_640] = '{
        17'h08000, 17'h04000, 17'h00000
    };
    localparam logic [IDX_W-1:0] BASE_320 [PLANES_320] = '{
        17'h08000, 17'h0A000, 17'h14000, 17'h16000,
        17'h04000, 17'h06000, 17'h10000, 17'h12000,
        17'h00000, 17'h02000, 17'h0C000, 17'h0E000
    };

    typedef enum logic [1:0] {
        CMD_READ,
        CMD_WRITE,
        CMD_FETCH
    } cmd_kind_t;

    // One classified operation as it travels from the front to the back.
    typedef struct packed {
        cmd_kind_t        kind;
        logic             hit;      // CPU access reaches memory
        logic [IDX_W-1:0] idx;      // CPU byte index
        logic [7:0]       wdata;
        logic [OFF_W-1:0] off;      // display byte offset within a plane
        logic             mode_320;
        logic [2:0]       dmask;    // display masks for R, G, B groups
    } vram_cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

    typedef struct packed {
        logic clearing;
    } back_status_t;

    // Byte index of plane j of a display fetch.
    function automatic logic [IDX_W-1:0] plane_addr(
        input logic             mode_320,
        input logic [3:0]       j,
        input logic [OFF_W-1:0] off
    );
        logic [IDX_W-1:0] a;
        if (mode_320)
        begin
            a = BASE_320[j] | {4'b0, off[12:0]};
        end
        else
        begin
            a = BASE_640[j[1:0]] | {3'b0, off};
        end
        return a;
    endfunction

    // True when plane j of a display fetch is masked off.
    function automatic logic plane_masked(
        input logic       mode_320,
        input logic [3:0] j,
        input logic [2:0] dmask
    );
        logic m;
        if (mode_320)
        begin
            m = (j < 4'd4) ? dmask[2] : (j < 4'd8) ? dmask[1] : dmask[0];
        end
        else
        begin
            m = (j == 4'd0) ? dmask[2] : (j == 4'd1) ? dmask[1] : dmask[0];
        end
        return m;
    endfunction

endpackage

[rtl/core/pvas_if.sv]
// Valid/ready channel interfaces for operation beats and result beats.
`timescale 1ns / 1ps

interface pvas_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [15:0] cpu_address;
    logic [7:0]  write_data;
    logic [7:0]  row;
    logic [6:0]  column;

    modport source (
        output valid, opcode, cpu_address, write_data, row, column,
        input  ready
    );
    modport sink (
        input  valid, opcode, cpu_address, write_data, row, column,
        output ready
    );
endinterface

interface pvas_out_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic [7:0]  read_data;
    logic [12:0] pixel_color;
    logic        last;

    modport source (
        output valid, result_kind, read_data, pixel_color, last,
        input  ready
    );
    modport sink (
        input  valid, result_kind, read_data, pixel_color, last,
        output ready
    );
endinterface

[rtl/core/pvas_front.sv]
// Front part: accepts operation beats, resolves addresses and masks, queues commands.
`timescale 1ns / 1ps

module pvas_front
    import pvas_pkg::*;
#(
    parameter int VRAM_BYTES = 98304
)
(
    pvas_in_if.sink          item,
    input  logic [6:0]       plane_mask,
    input  logic [15:0]      scroll_offset,
    input  logic             active_page,
    input  logic             cpu_access_enable,
    input  logic             mode_320,
    input  logic             display_enable,
    input  back_status_t     back_status,
    input  q_status_t        q_status,
    output logic             push,
    output vram_cmd_t        push_cmd
);

    logic             accept;
    logic             cpu_masked;
    logic [OFF_W-1:0] cpu_low;
    logic [IDX_W-1:0] cpu_idx;
    logic             cpu_hit;
    logic [13:0]      off_640;
    logic [12:0]      off_320;
    logic             keep;

    assign item.ready = !q_status.full && !back_status.clearing;
    assign accept     = item.valid && item.ready;

    // CPU side: plane mask by 16K region, scroll wrap inside the plane, page select.
    always_comb
    begin
        case (item.cpu_address[15:14])
            2'd0:    cpu_masked = plane_mask[0];
            2'd1:    cpu_masked = plane_mask[1];
            2'd2:    cpu_masked = plane_mask[2];
            default: cpu_masked = 1'b0;
        endcase
    end

    assign cpu_low = item.cpu_address[13:0] + scroll_offset[13:0];
    assign cpu_idx = {1'b0, item.cpu_address[15:14], cpu_low}
                   + (active_page ? PAGE_OFFSET : '0);
    assign cpu_hit = !cpu_masked && ({15'd0, cpu_idx} < 32'(VRAM_BYTES));

    // Display side: row times 80 or 40 built from shifts.
    assign off_640 = 14'({item.row, 6'b0}) + 14'({item.row, 4'b0})
                   + 14'(item.column) + scroll_offset[13:0];
    assign off_320 = 13'({item.row, 5'b0}) + 13'({item.row, 3'b0})
                   + 13'(item.column) + scroll_offset[12:0];

    always_comb
    begin
        push_cmd.hit      = cpu_hit;
        push_cmd.idx      = cpu_idx;
        push_cmd.wdata    = item.write_data;
        push_cmd.off      = mode_320 ? {1'b0, off_320} : off_640;
        push_cmd.mode_320 = mode_320;
        push_cmd.dmask    = plane_mask[6:4];
        push_cmd.kind     = CMD_READ;
        keep              = 1'b0;
        case (item.opcode)
            OP_READ:
            begin
                push_cmd.kind = CMD_READ;
                keep          = 1'b1;
            end
            OP_WRITE_GATED:
            begin
                push_cmd.kind = CMD_WRITE;
                keep          = cpu_hit && cpu_access_enable;
            end
            OP_WRITE_UNGATED:
            begin
                push_cmd.kind = CMD_WRITE;
                keep          = cpu_hit;
            end
            OP_FETCH:
            begin
                push_cmd.kind = CMD_FETCH;
                keep          = display_enable;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    // Operations with no effect and no result are taken and dropped here.
    assign push = accept && keep;

endmodule

[rtl/core/pvas_queue.sv]
// Short command queue between the front and back parts.
`timescale 1ns / 1ps

module pvas_queue
    import pvas_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  vram_cmd_t push_cmd,
    input  logic      pop,
    output vram_cmd_t pop_cmd,
    output q_status_t q_status
);

    localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CW = $clog2(Q_DEPTH + 1);

    vram_cmd_t       entry_reg [Q_DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW-1:0]   rd_ptr_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic            do_push;
    logic            do_pop;

    assign q_status.empty = (count_reg == '0);
    assign q_status.full  = (count_reg == CW'(Q_DEPTH));
    assign pop_cmd        = entry_reg[rd_ptr_reg];

    assign do_push = push && !q_status.full;
    assign do_pop  = pop && !q_status.empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CW'(do_push) - CW'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

[rtl/core/pvas_back.sv]
// Back part: owns the video memory, runs queued commands and drives result beats.
`timescale 1ns / 1ps

module pvas_back
    import pvas_pkg::*;
#(
    parameter int VRAM_BYTES = 98304
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  vram_cmd_t    pop_cmd,
    input  q_status_t    q_status,
    output logic         pop,
    output back_status_t back_status,
    pvas_out_if.source   result
);

    localparam int AW = $clog2(VRAM_BYTES);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RESP,
        S_FETCH,
        S_EMIT
    } state_t;

    logic [7:0]    mem [VRAM_BYTES];
    logic [7:0]    mem_q_reg;
    logic          mem_we;
    logic          mem_re;
    logic [AW-1:0] mem_addr;
    logic [7:0]    mem_wd;

    state_t        state_reg;
    state_t        state_next;
    logic [AW-1:0] clr_reg;
    logic [AW-1:0] clr_next;
    vram_cmd_t     cmd_reg;
    vram_cmd_t     cmd_next;
    logic [3:0]    iss_reg;
    logic [3:0]    iss_next;
    logic [3:0]    cap_reg;
    logic [3:0]    cap_next;
    logic          pend_reg;
    logic          pend_next;
    logic [2:0]    k_reg;
    logic [2:0]    k_next;
    logic [7:0]    p_reg [PLANES_320];
    logic [7:0]    p_next [PLANES_320];

    logic          out_valid_reg;
    logic          out_valid_next;
    logic          out_kind_reg;
    logic          out_kind_next;
    logic [7:0]    out_rdata_reg;
    logic [7:0]    out_rdata_next;
    logic [12:0]   out_pix_reg;
    logic [12:0]   out_pix_next;
    logic          out_last_reg;
    logic          out_last_next;

    logic          out_free;
    logic [3:0]    n_last;
    logic          issue;
    logic [11:0]   idx_320;
    logic [12:0]   pixel;

    assign out_free             = !out_valid_reg || result.ready;
    assign back_status.clearing = (state_reg == S_CLEAR);
    assign n_last = cmd_reg.mode_320 ? 4'(PLANES_320 - 1) : 4'(PLANES_640 - 1);
    assign issue  = (iss_reg <= n_last);

    // Pixel from the top bit of every plane byte; 640 mode uses the last three.
    always_comb
    begin
        for (int j = 0; j < PLANES_320; j++)
        begin
            idx_320[PLANES_320 - 1 - j] = p_reg[j][7];
        end
        if (cmd_reg.mode_320)
        begin
            pixel = {1'b0, idx_320} + COLOR_BASE_320;
        end
        else
        begin
            pixel = {10'b0, idx_320[2:0]};
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        cmd_next       = cmd_reg;
        iss_next       = iss_reg;
        cap_next       = cap_reg;
        pend_next      = pend_reg;
        k_next         = k_reg;
        p_next         = p_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_kind_next  = out_kind_reg;
        out_rdata_next = out_rdata_reg;
        out_pix_next   = out_pix_reg;
        out_last_next  = out_last_reg;
        pop            = 1'b0;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_addr       = '0;
        mem_wd         = '0;

        case (state_reg)
            S_CLEAR:
            begin
                mem_we   = 1'b1;
                mem_addr = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == AW'(VRAM_BYTES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (!q_status.empty)
                begin
                    pop      = 1'b1;
                    cmd_next = pop_cmd;
                    mem_addr = AW'(pop_cmd.idx);
                    case (pop_cmd.kind)
                        CMD_READ:
                        begin
                            mem_re     = pop_cmd.hit;
                            state_next = S_RESP;
                        end
                        CMD_WRITE:
                        begin
                            mem_we = 1'b1;
                            mem_wd = pop_cmd.wdata;
                        end
                        CMD_FETCH:
                        begin
                            iss_next   = '0;
                            cap_next   = '0;
                            pend_next  = 1'b0;
                            state_next = S_FETCH;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_READ;
                    out_rdata_next = cmd_reg.hit ? mem_q_reg : BYTE_MASKED;
                    out_pix_next   = '0;
                    out_last_next  = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_FETCH:
            begin
                // One plane read issued per cycle; its byte lands in the following cycle
                // and is shifted in at the highest-numbered entry of the plane buffer.
                if (issue)
                begin
                    mem_re   = 1'b1;
                    mem_addr = AW'(plane_addr(cmd_reg.mode_320, iss_reg, cmd_reg.off));
                    iss_next = iss_reg + 1'b1;
                end
                pend_next = issue;
                if (pend_reg)
                begin
                    for (int j = 0; j < PLANES_320 - 1; j++)
                    begin
                        p_next[j] = p_reg[j + 1];
                    end
                    p_next[PLANES_320 - 1] =
                        plane_masked(cmd_reg.mode_320, cap_reg, cmd_reg.dmask)
                        ? 8'd0 : mem_q_reg;
                    cap_next = cap_reg + 1'b1;
                    if (cap_reg == n_last)
                    begin
                        k_next     = '0;
                        state_next = S_EMIT;
                    end
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_PIXEL;
                    out_rdata_next = '0;
                    out_pix_next   = pixel;
                    out_last_next  = (k_reg == 3'd7);
                    for (int j = 0; j < PLANES_320; j++)
                    begin
                        p_next[j] = {p_reg[j][6:0], 1'b0};
                    end
                    k_next = k_reg + 1'b1;
                    if (k_reg == 3'd7)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            iss_reg       <= '0;
            cap_reg       <= '0;
            pend_reg      <= 1'b0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            iss_reg       <= iss_next;
            cap_reg       <= cap_next;
            pend_reg      <= pend_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        p_reg         <= p_next;
        out_kind_reg  <= out_kind_next;
        out_rdata_reg <= out_rdata_next;
        out_pix_reg   <= out_pix_next;
        out_last_reg  <= out_last_next;
    end

    // Single-port video memory with registered read data.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wd;
        end
        if (mem_re)
        begin
            mem_q_reg <= mem[mem_addr];
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.result_kind = out_kind_reg;
    assign result.read_data   = out_rdata_reg;
    assign result.pixel_color = out_pix_reg;
    assign result.last        = out_last_reg;

endmodule

[rtl/core/planar_vram_access_and_scanout.sv]
// Top level of the planar video memory block: register port, front, queue and back.
`timescale 1ns / 1ps

// Planar video memory of VRAM_BYTES bytes shared by CPU accesses and display
// scanout. Each input beat is a CPU read, a gated CPU write, an ungated CPU
// write or a display fetch; reads give one result beat, fetches with the
// display on give eight pixel beats (leftmost first, last set on the eighth),
// and everything else gives none. After reset the memory is swept to zero one
// byte per cycle; no input beat is taken during that sweep, while register
// writes are. A front part classifies each beat and drops those with no effect
// as they are accepted, and a two-entry queue feeds the back part, which owns
// the single memory port. Through that one port a write is a single access, a
// read is at most one access and then a result beat, a 640-mode fetch is three
// plane reads plus eight pixel beats, and a 320-mode fetch twelve plane reads
// plus eight pixel beats, since each plane byte needs its own memory access.
// Result beats wait in an output register, so a stalled result side stops the
// back part, and input beats as well once the queue is full.
// Registers sit at byte addresses 4*i: plane_mask, scroll_offset, active_page,
// cpu_access_enable, mode_320, display_enable; write them only while idle.

module planar_vram_access_and_scanout
    import pvas_pkg::*;
#(
    parameter int VRAM_BYTES = 98304
)
(
    input  logic        clk,
    input  logic        rst_n,
    pvas_in_if.sink     item,
    pvas_out_if.source  result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [6:0]   plane_mask_reg;
    logic [15:0]  scroll_offset_reg;
    logic         active_page_reg;
    logic         cpu_enable_reg;
    logic         mode_320_reg;
    logic         display_en_reg;

    logic         cfg_write;
    logic [2:0]   cfg_index;

    logic         push;
    vram_cmd_t    push_cmd;
    logic         pop;
    vram_cmd_t    pop_cmd;
    q_status_t    q_status;
    back_status_t back_status;

    // Register port: no wait states, writes land on the access cycle.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_mask_reg    <= '0;
            scroll_offset_reg <= '0;
            active_page_reg   <= 1'b0;
            cpu_enable_reg    <= 1'b0;
            mode_320_reg      <= 1'b0;
            display_en_reg    <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_PLANE_MASK:    plane_mask_reg    <= pwdata[6:0];
                REG_SCROLL_OFFSET: scroll_offset_reg <= pwdata[15:0];
                REG_ACTIVE_PAGE:   active_page_reg   <= pwdata[0];
                REG_CPU_ENABLE:    cpu_enable_reg    <= pwdata[0];
                REG_MODE_320:      mode_320_reg      <= pwdata[0];
                REG_DISPLAY_EN:    display_en_reg    <= pwdata[0];
                default:           plane_mask_reg    <= plane_mask_reg;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_index)
            REG_PLANE_MASK:    prdata = {25'd0, plane_mask_reg};
            REG_SCROLL_OFFSET: prdata = {16'd0, scroll_offset_reg};
            REG_ACTIVE_PAGE:   prdata = {31'd0, active_page_reg};
            REG_CPU_ENABLE:    prdata = {31'd0, cpu_enable_reg};
            REG_MODE_320:      prdata = {31'd0, mode_320_reg};
            REG_DISPLAY_EN:    prdata = {31'd0, display_en_reg};
            default:           prdata = '0;
        endcase
    end

    // The front resolves CPU indices and display offsets with the register
    // values current at acceptance; those travel with the command.
    pvas_front #(
        .VRAM_BYTES (VRAM_BYTES)
    ) u_front (
        .item              (item),
        .plane_mask        (plane_mask_reg),
        .scroll_offset     (scroll_offset_reg),
        .active_page       (active_page_reg),
        .cpu_access_enable (cpu_enable_reg),
        .mode_320          (mode_320_reg),
        .display_enable    (display_en_reg),
        .back_status       (back_status),
        .q_status          (q_status),
        .push              (push),
        .push_cmd          (push_cmd)
    );

    pvas_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .q_status (q_status)
    );

    // The back runs one command at a time against the memory and fills the
    // output register, one beat per cycle when the result side is ready.
    pvas_back #(
        .VRAM_BYTES (VRAM_BYTES)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .pop_cmd     (pop_cmd),
        .q_status    (q_status),
        .pop         (pop),
        .back_status (back_status),
        .result      (result)
    );

endmodule
